>>> src/bnpr_pkg.sv
// Shared types and constants for the 4-bit BMP palette remapper.
package bnpr_pkg;

    // Header layout
    localparam logic [6:0]  HDR_LEN     = 7'd118;
    localparam logic [6:0]  PAL_BASE    = 7'd54;
    localparam logic [6:0]  POS_SIG     = 7'd1;
    localparam logic [6:0]  POS_INFO    = 7'd17;
    localparam logic [6:0]  POS_WIDTH   = 7'd21;
    localparam logic [6:0]  POS_HEIGHT  = 7'd25;
    localparam logic [6:0]  POS_BITCNT  = 7'd29;
    localparam logic [6:0]  POS_COMPR   = 7'd33;
    localparam logic [6:0]  POS_LAST    = 7'd117;

    localparam logic [15:0] BMP_SIG     = 16'h4D42;   // "BM", little-endian
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] BIT_COUNT   = 16'd4;

    // Unmatched palette entry value
    localparam logic [7:0]  UNMATCHED   = 8'h21;

    // Palette channel levels
    localparam logic [7:0]  LVL_0       = 8'h00;
    localparam logic [7:0]  LVL_1       = 8'h55;
    localparam logic [7:0]  LVL_2       = 8'hAA;
    localparam logic [7:0]  LVL_3       = 8'hFF;

    // Palette entry byte slots (B, G, R, reserved)
    localparam logic [1:0]  SLOT_B      = 2'd0;
    localparam logic [1:0]  SLOT_G      = 2'd1;
    localparam logic [1:0]  SLOT_R      = 2'd2;

    typedef enum logic [1:0] {
        KIND_HDR   = 2'd0,
        KIND_PIX   = 2'd1,
        KIND_PAD   = 2'd2,
        KIND_TRAIL = 2'd3
    } byte_kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIG  = 3'd1,
        ST_INFO     = 3'd2,
        ST_BITCNT   = 3'd3,
        ST_COMPR    = 3'd4,
        ST_ODD_W    = 3'd5,
        ST_HEIGHT   = 3'd6
    } status_t;

    // Parser stage register contents
    typedef struct packed {
        logic       valid;
        byte_kind_t kind;
        logic [1:0] plane;
        logic       row_end;
        logic       image_end;
        status_t    status;
    } stage_t;

    // Palette map write
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [3:0] data;
    } pal_wr_t;

endpackage

>>> src/bnpr_palette.sv
// Nibble map memory with per-entry valid bits and registered dual read.
module bnpr_palette (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,      // file start: all entries back to unmatched
    input  bnpr_pkg::pal_wr_t wr,
    input  logic             rd_en,
    input  logic [3:0]       rd_hi_addr,
    input  logic [3:0]       rd_lo_addr,
    output logic [3:0]       rd_hi_data,
    output logic [3:0]       rd_lo_data,
    output logic             rd_hi_valid,
    output logic             rd_lo_valid
);
    import bnpr_pkg::*;

    logic [3:0]  map_mem [16];
    logic [15:0] valid_reg;
    logic [15:0] valid_next;
    logic [3:0]  hi_data_reg;
    logic [3:0]  lo_data_reg;
    logic        hi_valid_reg;
    logic        lo_valid_reg;

    // Valid bits: cleared at file start, set on write
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Memory write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            map_mem[wr.addr] <= wr.data;
        end
    end

    // Registered reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hi_data_reg  <= map_mem[rd_hi_addr];
            lo_data_reg  <= map_mem[rd_lo_addr];
            hi_valid_reg <= valid_reg[rd_hi_addr];
            lo_valid_reg <= valid_reg[rd_lo_addr];
        end
    end

    assign rd_hi_data  = hi_data_reg;
    assign rd_lo_data  = lo_data_reg;
    assign rd_hi_valid = hi_valid_reg;
    assign rd_lo_valid = lo_valid_reg;

endmodule

>>> src/bnpr_parser.sv
// Header parser, error latch, row/column counters and the input stage register.
module bnpr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,       // input transfer
    input  logic              move,       // stage register drains to output
    input  logic [7:0]        in_byte,
    input  logic              file_start,
    input  logic              quad_mode,
    output bnpr_pkg::stage_t  stage,
    output bnpr_pkg::pal_wr_t pal_wr
);
    import bnpr_pkg::*;

    logic [6:0]  pos_reg,      pos_next;
    logic [31:0] shift_reg,    shift_next;
    status_t     err_reg,      err_next;
    logic [29:0] pix_reg,      pix_next;
    logic [30:0] last_col_reg, last_col_next;
    logic        cols_ok_reg,  cols_ok_next;
    logic [30:0] rows_reg,     rows_next;
    logic        w_odd_reg,    w_odd_next;
    logic [1:0]  h_low_reg,    h_low_next;
    logic [30:0] row_reg,      row_next;
    logic [30:0] col_reg,      col_next;
    logic [15:0] entry_reg,    entry_next;
    stage_t      stage_reg,    stage_next;

    logic [6:0]  cur_pos;
    logic [31:0] cur_shift;
    status_t     cur_err;
    logic [30:0] cur_row;
    logic [30:0] cur_col;
    logic        in_hdr;
    status_t     new_err;
    logic [1:0]  pad;
    logic [30:0] row_len;
    logic [6:0]  pal_ofs;
    logic        in_pal;
    logic        r_ok;
    logic        b_ok;
    logic        g_ok;
    logic [1:0]  g_lvl;
    logic        active;
    logic        at_row_end;
    byte_kind_t  kind;

    // File start restarts the parser on this byte
    always_comb
    begin
        cur_pos   = file_start ? '0 : pos_reg;
        cur_shift = file_start ? '0 : shift_reg;
        cur_err   = file_start ? ST_OK : err_reg;
        cur_row   = file_start ? '0 : row_reg;
        cur_col   = file_start ? '0 : col_reg;
        in_hdr    = (cur_pos < HDR_LEN);
        shift_next = {in_byte, cur_shift[31:8]};
    end

    // Header field checks at fixed offsets
    always_comb
    begin
        new_err = ST_OK;
        if (in_hdr)
        begin
            case (cur_pos)
                POS_SIG:    if (shift_next[31:16] != BMP_SIG)   new_err = ST_BAD_SIG;
                POS_INFO:   if (shift_next != INFO_SIZE)        new_err = ST_INFO;
                POS_BITCNT: if (shift_next[31:16] != BIT_COUNT) new_err = ST_BITCNT;
                POS_COMPR:  if (shift_next != '0)               new_err = ST_COMPR;
                POS_LAST:
                begin
                    if (w_odd_reg)
                    begin
                        new_err = ST_ODD_W;
                    end
                    else if (h_low_reg != 2'd0)
                    begin
                        new_err = ST_HEIGHT;
                    end
                end
                default:    new_err = ST_OK;
            endcase
        end
        err_next = (cur_err != ST_OK) ? cur_err : new_err;
    end

    // Image geometry, captured as the width and height fields complete
    always_comb
    begin
        pix_next      = pix_reg;
        last_col_next = last_col_reg;
        cols_ok_next  = cols_ok_reg;
        rows_next     = rows_reg;
        w_odd_next    = w_odd_reg;
        h_low_next    = h_low_reg;
        pad           = 2'd0;
        row_len       = '0;
        if (in_hdr && cur_pos == POS_WIDTH)
        begin
            pix_next      = shift_next[31] ? '0 : shift_next[30:1];
            pad           = 2'(2'd0 - pix_next[1:0]);
            row_len       = 31'(pix_next) + 31'(pad);
            last_col_next = row_len - 31'd1;
            cols_ok_next  = (pix_next != '0);
            w_odd_next    = shift_next[0];
        end
        if (in_hdr && cur_pos == POS_HEIGHT)
        begin
            rows_next  = shift_next[31] ? '0 : shift_next[30:0];
            h_low_next = shift_next[1:0];
        end
    end

    // Palette entries: collect B and G, match on R
    always_comb
    begin
        pal_ofs    = 7'(cur_pos - PAL_BASE);
        in_pal     = in_hdr && (cur_pos >= PAL_BASE);
        entry_next = entry_reg;
        if (in_pal && pal_ofs[1:0] == SLOT_B)
        begin
            entry_next[7:0] = in_byte;
        end
        if (in_pal && pal_ofs[1:0] == SLOT_G)
        begin
            entry_next[15:8] = in_byte;
        end

        r_ok = in_byte inside {LVL_0, LVL_3};
        b_ok = entry_reg[7:0] inside {LVL_0, LVL_3};
        g_ok = 1'b1;
        case (entry_reg[15:8])
            LVL_0:   g_lvl = 2'd0;
            LVL_1:   g_lvl = 2'd1;
            LVL_2:   g_lvl = 2'd2;
            LVL_3:   g_lvl = 2'd3;
            default:
            begin
                g_lvl = 2'd0;
                g_ok  = 1'b0;
            end
        endcase

        pal_wr.en   = load && in_pal && (pal_ofs[1:0] == SLOT_R) && r_ok && b_ok && g_ok;
        pal_wr.addr = pal_ofs[5:2];
        pal_wr.data = {in_byte[0], entry_reg[0], g_lvl};
    end

    // Pixel area: classify the byte and step the counters
    always_comb
    begin
        active     = !in_hdr && cols_ok_reg && (cur_row < rows_reg);
        at_row_end = active && (cur_col == last_col_reg);
        row_next   = cur_row;
        col_next   = cur_col;
        if (in_hdr)
        begin
            kind = KIND_HDR;
        end
        else if (!active)
        begin
            kind = KIND_TRAIL;
        end
        else if (cur_col < 31'(pix_reg))
        begin
            kind = KIND_PIX;
        end
        else
        begin
            kind = KIND_PAD;
        end
        if (at_row_end)
        begin
            col_next = '0;
            row_next = cur_row + 31'd1;
        end
        else if (active)
        begin
            col_next = cur_col + 31'd1;
        end
        pos_next = in_hdr ? (cur_pos + 7'd1) : cur_pos;
    end

    // Stage register contents
    always_comb
    begin
        stage_next           = stage_reg;
        if (load)
        begin
            stage_next.valid     = 1'b1;
            stage_next.kind      = kind;
            stage_next.plane     = (active && quad_mode) ? cur_row[1:0] : 2'd0;
            stage_next.row_end   = at_row_end;
            stage_next.image_end = at_row_end && (cur_row == rows_reg - 31'd1);
            stage_next.status    = err_next;
        end
        else if (move)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            shift_reg    <= '0;
            err_reg      <= ST_OK;
            pix_reg      <= '0;
            last_col_reg <= '0;
            cols_ok_reg  <= 1'b0;
            rows_reg     <= '0;
            w_odd_reg    <= 1'b0;
            h_low_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            entry_reg    <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            if (load)
            begin
                pos_reg      <= pos_next;
                shift_reg    <= shift_next;
                err_reg      <= err_next;
                pix_reg      <= pix_next;
                last_col_reg <= last_col_next;
                cols_ok_reg  <= cols_ok_next;
                rows_reg     <= rows_next;
                w_odd_reg    <= w_odd_next;
                h_low_reg    <= h_low_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                entry_reg    <= entry_next;
            end
        end
    end

    assign stage = stage_reg;

endmodule

>>> src/bnpr_output.sv
// Result register: builds the remapped byte and holds the master-side transfer.
module bnpr_output (
    input  logic             clk,
    input  logic             rst_n,
    input  bnpr_pkg::stage_t stage,
    input  logic [3:0]       hi_data,
    input  logic [3:0]       lo_data,
    input  logic             hi_valid,
    input  logic             lo_valid,
    output logic             advance,    // result register can take a new item
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    output logic [2:0]       m_tuser
);
    import bnpr_pkg::*;

    logic        valid_reg,  valid_next;
    logic [15:0] data_reg,   data_next;
    logic        last_reg,   last_next;
    logic [2:0]  user_reg,   user_next;
    logic        move;
    logic [3:0]  hi_nib;
    logic [7:0]  lo_val;
    logic [7:0]  pix_byte;

    assign advance = !valid_reg || m_tready;
    assign move    = stage.valid && advance;

    // Unmatched high entry leaves its low nibble 1; unmatched low entry ORs in 0x21
    always_comb
    begin
        hi_nib   = hi_valid ? hi_data : UNMATCHED[3:0];
        lo_val   = lo_valid ? {4'h0, lo_data} : UNMATCHED;
        pix_byte = {hi_nib, 4'h0} | lo_val;
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        if (move)
        begin
            valid_next = 1'b1;
            data_next  = {3'b000, stage.status, stage.plane,
                          (stage.kind == KIND_PIX) ? pix_byte : 8'h00};
            last_next  = stage.row_end;
            user_next  = {stage.image_end, stage.kind};
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

>>> src/bmp4_nibble_palette_remapper_core.sv
// Top level of the 4-bit BMP palette remapper.
//
// Takes a 4-bit uncompressed BMP file one byte per transfer and returns one
// result per byte. Bytes 0..117 are the header; their fields are checked at
// fixed offsets and the first error is held in status until the next file
// start. Palette entries equal to one of the 16 fixed colors map to their
// color index, others to 0x21; pixel bytes are remapped nibble by nibble
// through that map, padding bytes are flagged, and bytes past the image are
// marked trailing. An input transfer passes through the parser stage with the
// map read, then the result register; one byte is taken every cycle while
// the master side accepts results, and the input keeps flowing while a result
// waits on the master side as long as the parser stage is free. It is up to the
// user that quad_mode is written only while the block is idle; the block does not enforce it.
module bmp4_nibble_palette_remapper_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // quad_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [7:0] in_byte
    input  logic        s_tuser,         // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,         // [7:0] out_byte, [9:8] plane, [12:10] status
    output logic        m_tlast,         // row_end
    output logic [2:0]  m_tuser          // [1:0] byte_kind, [2] image_end
);
    import bnpr_pkg::*;

    logic    quad_mode_reg;
    stage_t  stage;
    pal_wr_t pal_wr;
    logic    advance;
    logic    load;
    logic    move;
    logic [3:0] hi_data;
    logic [3:0] lo_data;
    logic    hi_valid;
    logic    lo_valid;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            quad_mode_reg <= cfg_wr_data;
        end
    end

    // Handshake between input, parser stage and result register
    assign move     = stage.valid && advance;
    assign s_tready = !stage.valid || advance;
    assign load     = s_tvalid && s_tready;

    bnpr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .move       (move),
        .in_byte    (s_tdata),
        .file_start (s_tuser),
        .quad_mode  (quad_mode_reg),
        .stage      (stage),
        .pal_wr     (pal_wr)
    );

    bnpr_palette u_palette (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (load && s_tuser),
        .wr          (pal_wr),
        .rd_en       (load),
        .rd_hi_addr  (s_tdata[7:4]),
        .rd_lo_addr  (s_tdata[3:0]),
        .rd_hi_data  (hi_data),
        .rd_lo_data  (lo_data),
        .rd_hi_valid (hi_valid),
        .rd_lo_valid (lo_valid)
    );

    bnpr_output u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .hi_data  (hi_data),
        .lo_data  (lo_data),
        .hi_valid (hi_valid),
        .lo_valid (lo_valid),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
